// File: src/dvicce_pkg.sv
// ----------------------------------------------------------------------------
// dvicce_pkg
// Shared types, request and command codes, and opcode tables for the DVI
// command coalescing encoder.
// ----------------------------------------------------------------------------
package dvicce_pkg;

  // request codes on the input channel
  localparam logic [3:0] REQ_RIGHT = 4'd0;
  localparam logic [3:0] REQ_DOWN  = 4'd1;
  localparam logic [3:0] REQ_SET   = 4'd2;
  localparam logic [3:0] REQ_PUT   = 4'd3;
  localparam logic [3:0] REQ_RULE  = 4'd4;
  localparam logic [3:0] REQ_FONT  = 4'd5;
  localparam logic [3:0] REQ_PUSH  = 4'd6;
  localparam logic [3:0] REQ_POP   = 4'd7;
  localparam logic [3:0] REQ_EOP   = 4'd8;
  localparam logic [3:0] REQ_NOP   = 4'd9;
  localparam logic [3:0] REQ_RAW   = 4'd10;

  // pending command kinds
  localparam logic [3:0] K_NOP    = 4'd0;
  localparam logic [3:0] K_RIGHT1 = 4'd1;
  localparam logic [3:0] K_RIGHT2 = 4'd2;
  localparam logic [3:0] K_RIGHT3 = 4'd3;
  localparam logic [3:0] K_RIGHT4 = 4'd4;
  localparam logic [3:0] K_DOWN1  = 4'd5;
  localparam logic [3:0] K_DOWN2  = 4'd6;
  localparam logic [3:0] K_DOWN3  = 4'd7;
  localparam logic [3:0] K_DOWN4  = 4'd8;
  localparam logic [3:0] K_SET    = 4'd9;
  localparam logic [3:0] K_PUT    = 4'd10;
  localparam logic [3:0] K_RULE   = 4'd11;
  localparam logic [3:0] K_FNT    = 4'd12;
  localparam logic [3:0] K_PUSH   = 4'd13;
  localparam logic [3:0] K_POP    = 4'd14;
  localparam logic [3:0] K_EOP    = 4'd15;

  // move sizing masks
  localparam logic [31:0] MASK_QUAD = 32'hff80_0000;
  localparam logic [31:0] MASK_TRIO = 32'h007f_8000;
  localparam logic [31:0] MASK_PAIR = 32'h0000_7f80;
  // negative down moves above -32767 fit in two bytes
  localparam logic [31:0] DOWN2_NEG_LIMIT = 32'hffff_8001;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] amount;
    logic signed [31:0] amount_two;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] byte_offset;
    logic        last_of_run;
  } out_item_t;

  // one emission job handed from front to back
  typedef struct packed {
    logic        raw;
    logic [3:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
  } job_t;

  // DVI opcode for each kind
  function automatic logic [7:0] opcode_of(input logic [3:0] kind);
    logic [7:0] op;
    unique case (kind)
      K_NOP:    op = 8'd138;
      K_RIGHT1: op = 8'd143;
      K_RIGHT2: op = 8'd144;
      K_RIGHT3: op = 8'd145;
      K_RIGHT4: op = 8'd146;
      K_DOWN1:  op = 8'd157;
      K_DOWN2:  op = 8'd158;
      K_DOWN3:  op = 8'd159;
      K_DOWN4:  op = 8'd160;
      K_SET:    op = 8'd128;
      K_PUT:    op = 8'd133;
      K_RULE:   op = 8'd137;
      K_FNT:    op = 8'd235;
      K_PUSH:   op = 8'd141;
      K_POP:    op = 8'd142;
      K_EOP:    op = 8'd140;
      default:  op = 8'd138;
    endcase
    return op;
  endfunction

  // number of bytes of the first value that follow the opcode
  function automatic logic [3:0] value_bytes(input logic [3:0] kind);
    logic [3:0] nb;
    unique case (kind)
      K_RIGHT1, K_DOWN1, K_SET, K_PUT, K_FNT: nb = 4'd1;
      K_RIGHT2, K_DOWN2:                      nb = 4'd2;
      K_RIGHT3, K_DOWN3:                      nb = 4'd3;
      K_RIGHT4, K_DOWN4, K_RULE:              nb = 4'd4;
      default:                                nb = 4'd0;
    endcase
    return nb;
  endfunction

  // index of the final byte of a job
  function automatic logic [3:0] job_last_idx(input job_t job);
    logic [3:0] idx;
    if (job.raw) begin
      idx = 4'd0;
    end else if (job.kind == K_RULE) begin
      idx = 4'd8;
    end else begin
      idx = value_bytes(job.kind);
    end
    return idx;
  endfunction

endpackage

// File: src/dvicce_front.sv
// ----------------------------------------------------------------------------
// dvicce_front
// Accepts requests, sizes moves, merges moves into the pending command and
// issues a job for each pending command that must go out, or for a raw byte.
// ----------------------------------------------------------------------------
module dvicce_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dvicce_pkg::in_item_t in_data,
  input  logic                q_full,
  output logic                push,
  output dvicce_pkg::job_t    push_job
);

  logic [3:0]  pend_kind_r, pend_kind_nxt;
  logic [31:0] pend_first_r, pend_first_nxt;
  logic [31:0] pend_second_r, pend_second_nxt;

  logic        accept;
  logic [31:0] a_val;
  logic [3:0]  new_kind;
  logic        is_cmd;
  logic        is_raw;
  logic        merge_down;
  logic        merge_right;

  // one job at most per transaction, so a free slot is all we need
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign a_val    = $unsigned(in_data.amount);

  function automatic logic [1:0] size_sel(input logic [31:0] v);
    logic [1:0] s;
    if ((v & dvicce_pkg::MASK_QUAD) != 32'd0) begin
      s = 2'd3;
    end else if ((v & dvicce_pkg::MASK_TRIO) != 32'd0) begin
      s = 2'd2;
    end else if ((v & dvicce_pkg::MASK_PAIR) != 32'd0) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

  // request decode and move sizing
  always_comb begin
    new_kind = dvicce_pkg::K_NOP;
    is_cmd   = 1'b1;
    is_raw   = 1'b0;
    unique case (in_data.req_type)
      dvicce_pkg::REQ_RIGHT: begin
        is_cmd   = (a_val != 32'd0);
        new_kind = dvicce_pkg::K_RIGHT1 + {2'b00, size_sel(a_val)};
      end
      dvicce_pkg::REQ_DOWN: begin
        is_cmd = (a_val != 32'd0);
        if (a_val[31]) begin
          new_kind = (a_val > dvicce_pkg::DOWN2_NEG_LIMIT) ? dvicce_pkg::K_DOWN2
                                                          : dvicce_pkg::K_DOWN4;
        end else begin
          new_kind = dvicce_pkg::K_DOWN1 + {2'b00, size_sel(a_val)};
        end
      end
      dvicce_pkg::REQ_SET:  new_kind = dvicce_pkg::K_SET;
      dvicce_pkg::REQ_PUT:  new_kind = dvicce_pkg::K_PUT;
      dvicce_pkg::REQ_RULE: new_kind = dvicce_pkg::K_RULE;
      dvicce_pkg::REQ_FONT: new_kind = dvicce_pkg::K_FNT;
      dvicce_pkg::REQ_PUSH: new_kind = dvicce_pkg::K_PUSH;
      dvicce_pkg::REQ_POP:  new_kind = dvicce_pkg::K_POP;
      dvicce_pkg::REQ_EOP:  new_kind = dvicce_pkg::K_EOP;
      dvicce_pkg::REQ_NOP:  new_kind = dvicce_pkg::K_NOP;
      dvicce_pkg::REQ_RAW: begin
        is_cmd = 1'b0;
        is_raw = 1'b1;
      end
      default: is_cmd = 1'b0;
    endcase
  end

  // merge checks against the pending command
  assign merge_down =
    (new_kind == dvicce_pkg::K_DOWN3 || new_kind == dvicce_pkg::K_DOWN4) &&
    (pend_kind_r == dvicce_pkg::K_DOWN3 || pend_kind_r == dvicce_pkg::K_DOWN4);
  assign merge_right = (new_kind == dvicce_pkg::K_RIGHT4) &&
    (pend_kind_r == dvicce_pkg::K_RIGHT3 || pend_kind_r == dvicce_pkg::K_RIGHT4);

  // pending update and job issue
  always_comb begin
    pend_kind_nxt   = pend_kind_r;
    pend_first_nxt  = pend_first_r;
    pend_second_nxt = pend_second_r;
    push            = 1'b0;
    push_job.raw    = 1'b0;
    push_job.kind   = pend_kind_r;
    push_job.first  = pend_first_r;
    push_job.second = pend_second_r;
    if (accept) begin
      if (is_raw) begin
        push            = 1'b1;
        push_job.raw    = 1'b1;
        push_job.kind   = dvicce_pkg::K_NOP;
        push_job.first  = a_val;
        push_job.second = 32'd0;
      end else if (is_cmd) begin
        if (merge_down) begin
          pend_first_nxt = pend_first_r + a_val;
          pend_kind_nxt  = dvicce_pkg::K_DOWN4;
        end else if (merge_right) begin
          pend_first_nxt = pend_first_r + a_val;
          pend_kind_nxt  = dvicce_pkg::K_RIGHT4;
        end else begin
          push            = 1'b1;
          pend_kind_nxt   = new_kind;
          pend_first_nxt  = a_val;
          pend_second_nxt = $unsigned(in_data.amount_two);
        end
      end
    end
  end

  // pending command registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_kind_r   <= dvicce_pkg::K_NOP;
      pend_first_r  <= 32'd0;
      pend_second_r <= 32'd0;
    end else begin
      pend_kind_r   <= pend_kind_nxt;
      pend_first_r  <= pend_first_nxt;
      pend_second_r <= pend_second_nxt;
    end
  end

endmodule

// File: src/dvicce_queue.sv
// ----------------------------------------------------------------------------
// dvicce_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module dvicce_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dvicce_pkg::job_t push_job,
  input  logic             pop,
  output dvicce_pkg::job_t head_job,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dvicce_pkg::job_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push == pop) |=> $stable(count_r)) else $error("queue count moved");
`endif

endmodule

// File: src/dvicce_back.sv
// ----------------------------------------------------------------------------
// dvicce_back
// Serializes queued jobs into DVI bytes, one per cycle unless stalled, tagging
// each with the running stream offset, through a registered output stage.
// ----------------------------------------------------------------------------
module dvicce_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dvicce_pkg::job_t      head_job,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dvicce_pkg::out_item_t out_data
);

  logic [3:0]            idx_r, idx_nxt;
  logic [31:0]           offset_r, offset_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dvicce_pkg::out_item_t out_data_r;

  logic       emit;
  logic       is_last;
  logic [7:0] cur_byte;

  // byte at position idx of a job: opcode, first value msb first, then second
  function automatic logic [7:0] pick_byte(input dvicce_pkg::job_t job,
                                           input logic [3:0] idx);
    logic [3:0] nb;
    logic [1:0] sh;
    logic [7:0] b;
    nb = dvicce_pkg::value_bytes(job.kind);
    sh = 2'd0;
    if (job.raw) begin
      b = job.first[7:0];
    end else if (idx == 4'd0) begin
      b = dvicce_pkg::opcode_of(job.kind);
    end else if (idx <= nb) begin
      sh = 2'(nb - idx);
      b  = job.first[{sh, 3'b000} +: 8];
    end else begin
      sh = 2'(4'd8 - idx);
      b  = job.second[{sh, 3'b000} +: 8];
    end
    return b;
  endfunction

  assign emit     = !q_empty && (!out_valid_r || !out_stall);
  assign is_last  = (idx_r == dvicce_pkg::job_last_idx(head_job));
  assign pop      = emit && is_last;
  assign cur_byte = pick_byte(head_job, idx_r);

  // byte index, stream offset and output valid
  always_comb begin
    idx_nxt       = idx_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = is_last ? 4'd0 : idx_r + 4'd1;
      offset_nxt    = offset_r + 32'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      offset_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte    <= cur_byte;
      out_data_r.byte_offset <= offset_r;
      out_data_r.last_of_run <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/dvi_command_coalescing_encoder.sv
// ----------------------------------------------------------------------------
// dvi_command_coalescing_encoder
// Encodes typesetting requests into a big-endian DVI byte stream, holding one
// command pending so that consecutive wide moves can merge.
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   dvicce_pkg::in_item_t
//   out_     output     out_valid/out_stall dvicce_pkg::out_item_t
//
// The front takes one request per cycle while the job queue has room.
// The back emits one byte per cycle while out_stall is low, so a request
// yields 1 to 9 bytes: opcode plus value bytes of the command it pushes out.
// A request that merges, is a zero move or an unused code emits nothing.
// Reset (rst_n low, synchronous) sets the pending command to no-operation and
// the stream offset to zero; out_stall holds the output register, and the
// queue absorbs requests until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module dvi_command_coalescing_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dvicce_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dvicce_pkg::out_item_t out_data
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  dvicce_pkg::job_t push_job;
  dvicce_pkg::job_t head_job;

  // request decode and merging
  dvicce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  dvicce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // byte serializer
  dvicce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DVI command coalescing encoder. Requests are
// queued by a stimulus process and offered by a clocked driver. Each accepted
// request goes through a local encoder model that keeps its own pending
// command and stream offset. Every emitted byte is compared with the oldest
// predicted byte. Sender gaps and receiver stalls change from phase to phase,
// and one long receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  dvicce_pkg::in_item_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dvicce_pkg::out_item_t out_data;

  dvi_command_coalescing_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // stimulus and scoreboard storage
  dvicce_pkg::in_item_t  request_queue[$];
  dvicce_pkg::out_item_t stream_bytes[$];
  dvicce_pkg::out_item_t want_byte;

  int queued_cnt     = 0;
  int taken_cnt      = 0;
  int checked_cnt    = 0;
  int merged_cnt     = 0;
  int ignored_cnt    = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;
  bit in_taken       = 1'b0;

  // local copy of the encoder state
  logic [3:0]  pend_kind   = dvicce_pkg::K_NOP;
  logic [31:0] pend_first  = '0;
  logic [31:0] pend_second = '0;
  logic [31:0] stream_pos  = '0;

  // size offset of a move by the sizing masks: 0 for one byte .. 3 for four
  function automatic logic [1:0] move_size(input logic [31:0] v);
    if ((v & dvicce_pkg::MASK_QUAD) != 0) return 2'd3;
    if ((v & dvicce_pkg::MASK_TRIO) != 0) return 2'd2;
    if ((v & dvicce_pkg::MASK_PAIR) != 0) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [7:0] dvi_opcode(input logic [3:0] kind);
    case (kind)
      dvicce_pkg::K_RIGHT1: return 8'd143;
      dvicce_pkg::K_RIGHT2: return 8'd144;
      dvicce_pkg::K_RIGHT3: return 8'd145;
      dvicce_pkg::K_RIGHT4: return 8'd146;
      dvicce_pkg::K_DOWN1:  return 8'd157;
      dvicce_pkg::K_DOWN2:  return 8'd158;
      dvicce_pkg::K_DOWN3:  return 8'd159;
      dvicce_pkg::K_DOWN4:  return 8'd160;
      dvicce_pkg::K_SET:    return 8'd128;
      dvicce_pkg::K_PUT:    return 8'd133;
      dvicce_pkg::K_RULE:   return 8'd137;
      dvicce_pkg::K_FNT:    return 8'd235;
      dvicce_pkg::K_PUSH:   return 8'd141;
      dvicce_pkg::K_POP:    return 8'd142;
      dvicce_pkg::K_EOP:    return 8'd140;
      default:              return 8'd138;
    endcase
  endfunction

  function automatic int arg_bytes(input logic [3:0] kind);
    case (kind)
      dvicce_pkg::K_RIGHT1, dvicce_pkg::K_DOWN1, dvicce_pkg::K_SET,
      dvicce_pkg::K_PUT, dvicce_pkg::K_FNT:                         return 1;
      dvicce_pkg::K_RIGHT2, dvicce_pkg::K_DOWN2:                    return 2;
      dvicce_pkg::K_RIGHT3, dvicce_pkg::K_DOWN3:                    return 3;
      dvicce_pkg::K_RIGHT4, dvicce_pkg::K_DOWN4, dvicce_pkg::K_RULE: return 4;
      default:                                                      return 0;
    endcase
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    dvicce_pkg::out_item_t t;
    t.out_byte    = b;
    t.byte_offset = stream_pos;
    t.last_of_run = 1'b0;
    stream_bytes.push_back(t);
    stream_pos = stream_pos + 32'd1;
  endtask

  // value bytes go out most significant first
  task automatic emit_value(input logic [31:0] v, input int count);
    for (int k = count; k > 0; k--) emit_byte(v[8*(k-1) +: 8]);
  endtask

  // predict the bytes caused by one accepted request
  task automatic encode_request(input dvicce_pkg::in_item_t it);
    logic [31:0]           a;
    logic [3:0]            kind;
    dvicce_pkg::out_item_t t;
    int                    start_size;
    bit                    takes_pending;
    a             = it.amount;
    kind          = dvicce_pkg::K_NOP;
    start_size    = stream_bytes.size();
    takes_pending = 1'b1;
    case (it.req_type)
      dvicce_pkg::REQ_RIGHT: begin
        if (a == 0) takes_pending = 1'b0;
        else kind = dvicce_pkg::K_RIGHT1 + {2'b00, move_size(a)};
      end
      dvicce_pkg::REQ_DOWN: begin
        if (a == 0) takes_pending = 1'b0;
        else if (a[31]) kind = (a > dvicce_pkg::DOWN2_NEG_LIMIT) ? dvicce_pkg::K_DOWN2
                                                                 : dvicce_pkg::K_DOWN4;
        else kind = dvicce_pkg::K_DOWN1 + {2'b00, move_size(a)};
      end
      dvicce_pkg::REQ_SET:  kind = dvicce_pkg::K_SET;
      dvicce_pkg::REQ_PUT:  kind = dvicce_pkg::K_PUT;
      dvicce_pkg::REQ_RULE: kind = dvicce_pkg::K_RULE;
      dvicce_pkg::REQ_FONT: kind = dvicce_pkg::K_FNT;
      dvicce_pkg::REQ_PUSH: kind = dvicce_pkg::K_PUSH;
      dvicce_pkg::REQ_POP:  kind = dvicce_pkg::K_POP;
      dvicce_pkg::REQ_EOP:  kind = dvicce_pkg::K_EOP;
      dvicce_pkg::REQ_NOP:  kind = dvicce_pkg::K_NOP;
      dvicce_pkg::REQ_RAW: begin
        // raw bytes bypass the pending command
        emit_byte(a[7:0]);
        takes_pending = 1'b0;
      end
      default: takes_pending = 1'b0;
    endcase
    if (!takes_pending && stream_bytes.size() == start_size) ignored_cnt++;
    if (takes_pending) begin
      if ((kind == dvicce_pkg::K_DOWN3 || kind == dvicce_pkg::K_DOWN4) &&
          (pend_kind == dvicce_pkg::K_DOWN3 || pend_kind == dvicce_pkg::K_DOWN4)) begin
        pend_first = pend_first + a;
        pend_kind  = dvicce_pkg::K_DOWN4;
        merged_cnt++;
      end else if (kind == dvicce_pkg::K_RIGHT4 &&
                   (pend_kind == dvicce_pkg::K_RIGHT3 ||
                    pend_kind == dvicce_pkg::K_RIGHT4)) begin
        pend_first = pend_first + a;
        pend_kind  = dvicce_pkg::K_RIGHT4;
        merged_cnt++;
      end else begin
        // push out the pending command, then hold the new one
        emit_byte(dvi_opcode(pend_kind));
        emit_value(pend_first, arg_bytes(pend_kind));
        if (pend_kind == dvicce_pkg::K_RULE) emit_value(pend_second, 4);
        pend_kind   = kind;
        pend_first  = a;
        pend_second = it.amount_two;
      end
    end
    // mark the final byte of this run
    if (stream_bytes.size() > start_size) begin
      t = stream_bytes.pop_back();
      t.last_of_run = 1'b1;
      stream_bytes.push_back(t);
    end
  endtask

  // output check and prediction on accepted transactions
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stream_bytes.size() == 0) begin
          $error("unexpected byte %02h at offset %0d", out_data.out_byte,
                 out_data.byte_offset);
          mismatches++;
        end else begin
          want_byte = stream_bytes.pop_front();
          checked_cnt++;
          if (out_data.out_byte !== want_byte.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want_byte.out_byte,
                   out_data.out_byte);
            mismatches++;
          end
          if (out_data.byte_offset !== want_byte.byte_offset) begin
            $error("byte_offset: expected %0d, got %0d", want_byte.byte_offset,
                   out_data.byte_offset);
            mismatches++;
          end
          if (out_data.last_of_run !== want_byte.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want_byte.last_of_run,
                   out_data.last_of_run);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        taken_cnt++;
        encode_request(in_data);
      end
    end
  end

  // request driver: holds a stalled transaction, otherwise may take a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // byte receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(input logic [3:0] req, input logic [31:0] a,
                               input logic [31:0] b);
    dvicce_pkg::in_item_t it;
    it.req_type   = req;
    it.amount     = a;
    it.amount_two = b;
    request_queue.push_back(it);
    queued_cnt++;
  endtask

  function automatic logic [31:0] any_amount();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return $urandom_range(127, 1);
      2:       return $urandom_range(32767, 128);
      3:       return $urandom_range(32'h007f_ffff, 32'h0000_8000);
      4:       return 32'd0 - $urandom_range(32766, 1);
      5:       return 32'hffff_8000 + $urandom_range(2, 0);
      6:       return $urandom | 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // amounts that mostly size to three or four bytes so moves merge
  function automatic logic [31:0] merge_amount(input bit down);
    case ($urandom_range(3))
      0:       return $urandom_range(32'h007f_ffff, 32'h0000_8000);
      1:       return $urandom | 32'h0080_0000;
      2:       return down ? 32'd0 - $urandom_range(32'h7fff_ffff, 32'h0000_7fff)
                           : $urandom;
      default: return any_amount();
    endcase
  endfunction

  // runs of moves with random content, single requests and unused codes
  task automatic queue_random(input int count);
    int         n;
    int         pick;
    int         len;
    logic [3:0] req;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(19);
      if (pick < 11) begin
        req = $urandom_range(1) ? dvicce_pkg::REQ_DOWN : dvicce_pkg::REQ_RIGHT;
        len = $urandom_range(6, 2);
        repeat (len) begin
          if ($urandom_range(7) == 0) begin
            queue_request(dvicce_pkg::REQ_RAW, $urandom, $urandom);
          end
          queue_request(req, merge_amount(req == dvicce_pkg::REQ_DOWN), $urandom);
        end
        n += len;
      end else if (pick < 19) begin
        queue_request($urandom_range(10, 0), any_amount(), $urandom);
        n++;
      end else begin
        queue_request($urandom_range(15, 11), $urandom, $urandom);
      end
    end
  endtask

  // wait until every request is taken and every byte has come out
  task automatic drain_and_settle();
    while (taken_cnt != queued_cnt || stream_bytes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 27;
    recv_stall_pct = 49;

    // directed: sizing boundaries, merges, wrap, zero moves, every command
    queue_request(dvicce_pkg::REQ_NOP,   32'd0, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h0000_0001, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h0000_0080, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h0000_7fff, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h0000_8000, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h007f_ffff, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h0080_0000, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h7fff_ffff, 32'd0);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'd0, 32'hffff_ffff);
    queue_request(dvicce_pkg::REQ_RIGHT, 32'h8000_0000, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'h0001_0000, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'hffff_8001, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'hffff_8002, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'd0, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'h7fff_ffff, 32'd0);
    queue_request(dvicce_pkg::REQ_DOWN,  32'h8000_0000, 32'd0);
    queue_request(dvicce_pkg::REQ_RAW,   32'h0000_01ff, 32'd0);
    queue_request(dvicce_pkg::REQ_SET,   32'h0000_00ff, 32'd0);
    queue_request(dvicce_pkg::REQ_PUT,   32'd0, 32'd0);
    queue_request(dvicce_pkg::REQ_RULE,  32'h8000_0000, 32'h7fff_ffff);
    queue_request(dvicce_pkg::REQ_FONT,  32'hffff_ffff, 32'd0);
    queue_request(dvicce_pkg::REQ_PUSH,  32'd0, 32'd0);
    queue_request(dvicce_pkg::REQ_POP,   32'd0, 32'd0);
    queue_request(dvicce_pkg::REQ_EOP,   32'd0, 32'd0);
    queue_request(4'd15,                 32'hffff_ffff, 32'hffff_ffff);
    queue_request(dvicce_pkg::REQ_RULE,  32'h7fff_ffff, 32'h8000_0000);

    queue_random(130);
    drain_and_settle();

    send_idle_pct  = 49;
    recv_stall_pct = 27;
    queue_random(130);
    drain_and_settle();

    // no idling; the receiver holds off long enough to back up the input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    queue_random(130);
    drain_and_settle();

    $display("Run covered %0d requests (%0d merged moves, %0d without output)",
             taken_cnt, merged_cnt, ignored_cnt);
    $display("and %0d stream bytes compared under three idle patterns", checked_cnt);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: dvi_command_coalescing_encoder.f
src/dvicce_pkg.sv
src/dvicce_front.sv
src/dvicce_queue.sv
src/dvicce_back.sv
src/dvi_command_coalescing_encoder.sv
tb/testbench.sv
